// ===== hdl/spq_pkg.sv =====
// spq_pkg: entry, result types and command/status codes for the sorted priority queue.
// Used by spq_mem, spq_ctrl and sorted_priority_queue. No dependencies.
`default_nettype none

package spq_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_DELETED   = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  localparam int OCC_W = 5;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } entry_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value;
    logic signed [31:0] prio;
    logic [OCC_W-1:0]   occupancy;
  } res_t;

  // signed a <= b
  function automatic logic prio_le(input logic signed [31:0] a, input logic signed [31:0] b);
    return a <= b;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/spq_mem.sv =====
// spq_mem: entry store, one write port and one read port, registered read data.
// Depends on spq_pkg (entry_t).
`default_nettype none

module spq_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [AW-1:0]  waddr,
  input  wire spq_pkg::entry_t wdata,
  input  wire logic           re,
  input  wire logic [AW-1:0]  raddr,
  output spq_pkg::entry_t     rdata
);
  import spq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/spq_ctrl.sv =====
// spq_ctrl: sequencer that keeps the store as a sorted circular list.
// Depends on spq_pkg; drives the ports of spq_mem.
`default_nettype none

module spq_ctrl #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4,
  parameter int CW       = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_cmd,
  input  wire logic signed [31:0] in_item_value,
  input  wire logic signed [31:0] in_item_priority,
  output logic                    res_valid,
  input  wire logic               res_take,
  output spq_pkg::res_t           res,
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output spq_pkg::entry_t         mem_wdata,
  output logic                    mem_re,
  output logic [AW-1:0]           mem_raddr,
  input  wire spq_pkg::entry_t    mem_rdata
);
  import spq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DEL_RD = 3'd1;
  localparam logic [2:0] S_INS_HD = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL = CW'(CAPACITY);

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST : p - AW'(1);
  endfunction

  logic [2:0]      state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [AW-1:0]   tail_r, tail_nxt;   // next free slot
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   scan_r, scan_nxt;   // slot whose data returns this cycle
  logic [AW-1:0]   wp_r, wp_nxt;       // hole left by the shift
  entry_t          new_r, new_nxt;
  logic [1:0]      status_r, status_nxt;
  entry_t          out_r, out_nxt;

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    scan_nxt   = scan_r;
    wp_nxt     = wp_r;
    new_nxt    = new_r;
    status_nxt = status_r;
    out_nxt    = out_r;
    mem_we     = 1'b0;
    mem_waddr  = tail_r;
    mem_wdata  = new_r;
    mem_re     = 1'b0;
    mem_raddr  = head_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          new_nxt.value = in_item_value;
          new_nxt.prio  = in_item_priority;
          out_nxt       = '0;
          if (in_cmd == CMD_DELETE) begin
            if (count_r == '0) begin
              status_nxt = ST_UNDERFLOW;
              state_nxt  = S_DONE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = head_r;
              state_nxt = S_DEL_RD;
            end
          end else if (count_r == FULL) begin
            status_nxt = ST_OVERFLOW;
            state_nxt  = S_DONE;
          end else if (count_r == '0) begin
            // empty: drop straight into the free slot
            mem_we          = 1'b1;
            mem_waddr       = tail_r;
            mem_wdata.value = in_item_value;
            mem_wdata.prio  = in_item_priority;
            tail_nxt        = inc(tail_r);
            count_nxt       = count_r + CW'(1);
            status_nxt      = ST_INSERTED;
            state_nxt       = S_DONE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = head_r;
            state_nxt = S_INS_HD;
          end
        end
      end

      S_DEL_RD: begin
        out_nxt    = mem_rdata;
        head_nxt   = inc(head_r);
        count_nxt  = count_r - CW'(1);
        status_nxt = ST_DELETED;
        state_nxt  = S_DONE;
      end

      S_INS_HD: begin
        status_nxt = ST_INSERTED;
        if (prio_le(new_r.prio, mem_rdata.prio)) begin
          // tie with head goes in front
          mem_we    = 1'b1;
          mem_waddr = dec(head_r);
          head_nxt  = dec(head_r);
          count_nxt = count_r + CW'(1);
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = dec(tail_r);
          scan_nxt  = dec(tail_r);
          wp_nxt    = tail_r;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // walk back from the tail; the head always stops the walk
        mem_we = 1'b1;
        if (prio_le(mem_rdata.prio, new_r.prio)) begin
          mem_waddr = wp_r;
          mem_wdata = new_r;
          tail_nxt  = inc(tail_r);
          count_nxt = count_r + CW'(1);
          state_nxt = S_DONE;
        end else begin
          mem_waddr = wp_r;
          mem_wdata = mem_rdata;
          wp_nxt    = scan_r;
          scan_nxt  = dec(scan_r);
          mem_re    = 1'b1;
          mem_raddr = dec(scan_r);
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r   <= scan_nxt;
    wp_r     <= wp_nxt;
    new_r    <= new_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  assign in_stall      = (state_r != S_IDLE);
  assign res_valid     = (state_r == S_DONE);
  assign res.status    = status_r;
  assign res.value     = out_r.value;
  assign res.prio      = out_r.prio;
  assign res.occupancy = OCC_W'(count_r);

endmodule

`default_nettype wire

// ===== hdl/sorted_priority_queue.sv =====
// sorted_priority_queue: top level, minimum-first queue kept sorted in one RAM.
// Depends on spq_pkg, spq_mem and spq_ctrl.
//
// Usage:
//   Input channel in_valid/in_stall carries in_cmd (0 insert, 1 delete head),
//   in_item_value and in_item_priority. A transfer happens when in_valid is
//   high and in_stall low. The block works on one command at a time.
//   Result channel out_valid/out_stall carries out_status, out_value,
//   out_priority and out_occupancy; exactly one result per command.
//   From the input transfer to out_valid: underflow, overflow and insert
//   into an empty queue go straight to the result; delete and insert at
//   or before the head first read the head; insert behind the head then
//   walks back from the tail, shifting each entry with a larger priority
//   value one slot tailward.
//   The next command is taken in the cycle after the result moves into the
//   output register. The shift walk is the cost of an insert: the single RAM
//   moves one entry per cycle, read and write in the same cycle.
//   Entries live in a circular buffer: delete advances the head pointer,
//   an insert in front of the head backs it up.
//   Reset (rst_n low, synchronous) empties the queue; RAM contents are not
//   cleared since only occupied slots are ever read.
//   A stalled result holds in the output register; the sequencer may still
//   take one new command and finish it, then waits until the register frees.
`default_nettype none

module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_cmd,
  input  wire logic signed [31:0] in_item_value,
  input  wire logic signed [31:0] in_item_priority,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_value,
  output logic signed [31:0]      out_priority,
  output logic [4:0]              out_occupancy
);
  import spq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  entry_t          mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  entry_t          mem_rdata;

  logic            res_valid;
  logic            res_take;
  res_t            res;

  logic            out_valid_r, out_valid_nxt;
  res_t            out_r;

  spq_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  spq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .res_valid        (res_valid),
    .res_take         (res_take),
    .res              (res),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_re           (mem_re),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata)
  );

  // output register: free when empty or its transfer completes this cycle
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_r.status;
  assign out_value     = out_r.value;
  assign out_priority  = out_r.prio;
  assign out_occupancy = out_r.occupancy;

endmodule

`default_nettype wire

// ===== hdl/spq_checker.sv =====
// spq_checker: port-level assertions for sorted_priority_queue, bound to the top level.
// Depends on spq_pkg for status codes.
`default_nettype none

module spq_checker #(
  parameter int CAPACITY = 16
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_status,
  input wire logic [31:0] out_value,
  input wire logic [31:0] out_priority,
  input wire logic [4:0]  out_occupancy
);
  import spq_pkg::*;

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one command at a time
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second command taken while busy");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_UNDERFLOW) |-> (out_occupancy == 5'd0))
    else $error("underflow with nonzero occupancy");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OVERFLOW) |-> (out_occupancy == 5'(CAPACITY)))
    else $error("overflow below capacity");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_status) && $stable(out_value) &&
       $stable(out_priority) && $stable(out_occupancy)))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_value     (out_value),
  .out_priority  (out_priority),
  .out_occupancy (out_occupancy)
);

`default_nettype wire
